@@ sv/vpsh_pkg.sv @@
// Shared codes and types for the volume point / sphere hit test pipeline.
// No dependencies; every other file in this block refers to it by scoped names.
package vpsh_pkg;

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_SPHERE = 1'b1;

  localparam logic [1:0] VT_BOX    = 2'd0;
  localparam logic [1:0] VT_SPHERE = 2'd1;

  // Per-request tag that travels with the data down the pipeline.
  typedef struct packed {
    logic       op;
    logic [1:0] vol_type;
    logic       in_box;
  } tag_t;

endpackage

@@ sv/vpsh_bound.sv @@
// Stage 1: orders box bounds per axis, runs the point-in-box compares, forms the radius.
// Depends on vpsh_pkg.
module vpsh_bound #(
  parameter int CB = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 v_in,
  input  logic                 op,
  input  logic [1:0]           vol_type,
  input  logic signed [CB-1:0] vol_word_0,
  input  logic signed [CB-1:0] vol_word_1,
  input  logic signed [CB-1:0] vol_word_2,
  input  logic signed [CB-1:0] vol_word_3,
  input  logic signed [CB-1:0] vol_word_4,
  input  logic signed [CB-1:0] vol_word_5,
  input  logic signed [CB-1:0] query_x,
  input  logic signed [CB-1:0] query_y,
  input  logic signed [CB-1:0] query_z,
  input  logic [CB-2:0]        query_radius,
  output logic                 v_out,
  output vpsh_pkg::tag_t       tag,
  output logic signed [CB-1:0] lo [3],
  output logic signed [CB-1:0] hi [3],
  output logic signed [CB-1:0] q [3],
  output logic signed [CB:0]   rad
);

  logic signed [CB-1:0] a [3];
  logic signed [CB-1:0] b [3];
  logic signed [CB-1:0] qn [3];
  logic signed [CB-1:0] lo_next [3];
  logic signed [CB-1:0] hi_next [3];
  logic signed [CB:0]   r_ext;
  logic signed [CB:0]   big_r_ext;
  logic signed [CB:0]   rad_next;
  vpsh_pkg::tag_t       tag_next;
  logic                 is_sphere;

  assign is_sphere = (vol_type == vpsh_pkg::VT_SPHERE);
  assign qn[0] = query_x;
  assign qn[1] = query_y;
  assign qn[2] = query_z;

  always_comb begin
    // A sphere becomes a degenerate interval at its center on each axis.
    if (is_sphere) begin
      a[0] = vol_word_0; b[0] = vol_word_0;
      a[1] = vol_word_1; b[1] = vol_word_1;
      a[2] = vol_word_2; b[2] = vol_word_2;
    end else begin
      a[0] = vol_word_0; b[0] = vol_word_1;
      a[1] = vol_word_2; b[1] = vol_word_3;
      a[2] = vol_word_4; b[2] = vol_word_5;
    end
    for (int i = 0; i < 3; i++) begin
      lo_next[i] = (a[i] < b[i]) ? a[i] : b[i];
      hi_next[i] = (a[i] < b[i]) ? b[i] : a[i];
    end
  end

  always_comb begin
    r_ext     = $signed({2'b00, query_radius});
    big_r_ext = $signed({vol_word_3[CB-1], vol_word_3});
    if (!is_sphere) begin
      rad_next = r_ext;
    end else if (op == vpsh_pkg::OP_SPHERE) begin
      rad_next = r_ext + big_r_ext;
    end else begin
      rad_next = big_r_ext;
    end
    tag_next.op       = op;
    tag_next.vol_type = vol_type;
    // Bounds in the given order: an inverted box holds no point.
    tag_next.in_box   = (query_x >= vol_word_0) && (query_x <= vol_word_1) &&
                        (query_y >= vol_word_2) && (query_y <= vol_word_3) &&
                        (query_z >= vol_word_4) && (query_z <= vol_word_5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (load) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag <= tag_next;
      rad <= rad_next;
      for (int i = 0; i < 3; i++) begin
        lo[i] <= lo_next[i];
        hi[i] <= hi_next[i];
        q[i]  <= qn[i];
      end
    end
  end

endmodule

@@ sv/vpsh_gap.sv @@
// Stage 2: distance from the query to each axis interval, and the radius magnitude.
// Depends on vpsh_pkg.
module vpsh_gap #(
  parameter int CB = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 v_in,
  input  vpsh_pkg::tag_t       tag_in,
  input  logic signed [CB-1:0] lo [3],
  input  logic signed [CB-1:0] hi [3],
  input  logic signed [CB-1:0] q [3],
  input  logic signed [CB:0]   rad,
  output logic                 v_out,
  output vpsh_pkg::tag_t       tag,
  output logic [CB-1:0]        gap [3],
  output logic [CB-1:0]        rad_mag
);

  logic signed [CB:0] d_lo [3];
  logic signed [CB:0] d_hi [3];
  logic [CB-1:0]      gap_next [3];
  logic signed [CB:0] rad_neg;
  logic [CB-1:0]      rad_mag_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_lo[i] = $signed({lo[i][CB-1], lo[i]}) - $signed({q[i][CB-1], q[i]});
      d_hi[i] = $signed({q[i][CB-1], q[i]}) - $signed({hi[i][CB-1], hi[i]});
      if (q[i] < lo[i]) begin
        gap_next[i] = d_lo[i][CB-1:0];
      end else if (q[i] > hi[i]) begin
        gap_next[i] = d_hi[i][CB-1:0];
      end else begin
        gap_next[i] = '0;
      end
    end
    rad_neg      = -rad;
    rad_mag_next = rad[CB] ? rad_neg[CB-1:0] : rad[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (load) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag     <= tag_in;
      rad_mag <= rad_mag_next;
      for (int i = 0; i < 3; i++) begin
        gap[i] <= gap_next[i];
      end
    end
  end

endmodule

@@ sv/vpsh_square.sv @@
// Stage 3: squares the three axis gaps and the radius magnitude.
// Depends on vpsh_pkg.
module vpsh_square #(
  parameter int CB = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              v_in,
  input  vpsh_pkg::tag_t    tag_in,
  input  logic [CB-1:0]     gap [3],
  input  logic [CB-1:0]     rad_mag,
  output logic              v_out,
  output vpsh_pkg::tag_t    tag,
  output logic [2*CB-1:0]   sq [3],
  output logic [2*CB-1:0]   rad_sq
);

  logic [2*CB-1:0] sq_next [3];
  logic [2*CB-1:0] rad_sq_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_next[i] = (2*CB)'(gap[i]) * (2*CB)'(gap[i]);
    end
    rad_sq_next = (2*CB)'(rad_mag) * (2*CB)'(rad_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (load) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag    <= tag_in;
      rad_sq <= rad_sq_next;
      for (int i = 0; i < 3; i++) begin
        sq[i] <= sq_next[i];
      end
    end
  end

endmodule

@@ sv/vpsh_decide.sv @@
// Stage 4: sums the squared gaps, compares against the squared radius, holds the result.
// Depends on vpsh_pkg.
module vpsh_decide #(
  parameter int CB = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              v_in,
  input  vpsh_pkg::tag_t    tag_in,
  input  logic [2*CB-1:0]   sq [3],
  input  logic [2*CB-1:0]   rad_sq,
  output logic              v_out,
  output logic              hit
);

  logic [2*CB+1:0] sum;
  logic [2*CB+1:0] rad_sq_ext;
  logic            le;
  logic            lt;
  logic            hit_next;

  always_comb begin
    sum        = (2*CB+2)'(sq[0]) + (2*CB+2)'(sq[1]) + (2*CB+2)'(sq[2]);
    rad_sq_ext = (2*CB+2)'(rad_sq);
    le         = (sum <= rad_sq_ext);
    lt         = (sum < rad_sq_ext);
    case (tag_in.vol_type)
      vpsh_pkg::VT_BOX:    hit_next = (tag_in.op == vpsh_pkg::OP_POINT) ? tag_in.in_box : le;
      // Sphere against sphere is a strict test.
      vpsh_pkg::VT_SPHERE: hit_next = (tag_in.op == vpsh_pkg::OP_POINT) ? le : lt;
      default:             hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (load) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hit <= hit_next;
    end
  end

endmodule

@@ sv/volume_point_sphere_hit_test.sv @@
// Top level of the volume point / sphere hit test: four-stage pipeline and its stall ladder.
// Depends on vpsh_pkg, vpsh_bound, vpsh_gap, vpsh_square, vpsh_decide.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_stall | op, vol_type, vol_word_0..5, query_x/y/z, query_radius
//   out     | out_valid/out_stall | hit
//
// One request per cycle while the output is not stalled; each result passes through the
// four register stages (bound order, gap, square, sum and compare) after its request is taken.
// Synchronous reset clears every stage valid bit; payload registers are not reset.
// A stage takes new data whenever it is empty or the stage after it moves, so bubbles
// close up and a stalled result still leaves room for three requests behind it.
module volume_point_sphere_hit_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [1:0]                   vol_type,
  input  logic signed [COORD_BITS-1:0] vol_word_0,
  input  logic signed [COORD_BITS-1:0] vol_word_1,
  input  logic signed [COORD_BITS-1:0] vol_word_2,
  input  logic signed [COORD_BITS-1:0] vol_word_3,
  input  logic signed [COORD_BITS-1:0] vol_word_4,
  input  logic signed [COORD_BITS-1:0] vol_word_5,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] query_z,
  input  logic [COORD_BITS-2:0]        query_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit
);

  localparam int CB = COORD_BITS;

  logic load1, load2, load3, load4;
  logic v1, v2, v3;

  vpsh_pkg::tag_t       tag1, tag2, tag3;
  logic signed [CB-1:0] lo [3];
  logic signed [CB-1:0] hi [3];
  logic signed [CB-1:0] q [3];
  logic signed [CB:0]   rad;
  logic [CB-1:0]        gap [3];
  logic [CB-1:0]        rad_mag;
  logic [2*CB-1:0]      sq [3];
  logic [2*CB-1:0]      rad_sq;

  // Advance a stage when it is empty or its successor advances.
  assign load4    = !out_valid || !out_stall;
  assign load3    = !v3 || load4;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign in_stall = !load1;

  vpsh_bound #(.CB(CB)) u_bound (
    .clk          (clk),
    .rst          (rst),
    .load         (load1),
    .v_in         (in_valid),
    .op           (op),
    .vol_type     (vol_type),
    .vol_word_0   (vol_word_0),
    .vol_word_1   (vol_word_1),
    .vol_word_2   (vol_word_2),
    .vol_word_3   (vol_word_3),
    .vol_word_4   (vol_word_4),
    .vol_word_5   (vol_word_5),
    .query_x      (query_x),
    .query_y      (query_y),
    .query_z      (query_z),
    .query_radius (query_radius),
    .v_out        (v1),
    .tag          (tag1),
    .lo           (lo),
    .hi           (hi),
    .q            (q),
    .rad          (rad)
  );

  vpsh_gap #(.CB(CB)) u_gap (
    .clk     (clk),
    .rst     (rst),
    .load    (load2),
    .v_in    (v1),
    .tag_in  (tag1),
    .lo      (lo),
    .hi      (hi),
    .q       (q),
    .rad     (rad),
    .v_out   (v2),
    .tag     (tag2),
    .gap     (gap),
    .rad_mag (rad_mag)
  );

  vpsh_square #(.CB(CB)) u_square (
    .clk     (clk),
    .rst     (rst),
    .load    (load3),
    .v_in    (v2),
    .tag_in  (tag2),
    .gap     (gap),
    .rad_mag (rad_mag),
    .v_out   (v3),
    .tag     (tag3),
    .sq      (sq),
    .rad_sq  (rad_sq)
  );

  vpsh_decide #(.CB(CB)) u_decide (
    .clk     (clk),
    .rst     (rst),
    .load    (load4),
    .v_in    (v3),
    .tag_in  (tag3),
    .sq      (sq),
    .rad_sq  (rad_sq),
    .v_out   (out_valid),
    .hit     (hit)
  );

  // Input backs up only when every stage is full and the output is blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  // A full, blocked pipeline keeps every request.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && out_valid && out_stall) |=> (v1 && v2 && v3 && out_valid))
    else $error("request lost while the pipeline was stalled");

  // A request in the square stage reaches the output unless the output is blocked.
  a_last_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (v3 && !(out_valid && out_stall)) |=> out_valid)
    else $error("request in the square stage did not reach the output");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !out_valid))
    else $error("pipeline not empty after reset");

endmodule

@@ tb/sv/hit_test_scoreboard.sv @@
// Scoreboard for the volume point / sphere hit test: watches both channels,
// predicts each hit flag and compares it with the block's result in order.
// Depends on vpsh_pkg for the op and volume type codes.
`timescale 1ns / 1ps

module hit_test_scoreboard #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         op,
  input  logic [1:0]                   vol_type,
  input  logic signed [COORD_BITS-1:0] vol_word_0,
  input  logic signed [COORD_BITS-1:0] vol_word_1,
  input  logic signed [COORD_BITS-1:0] vol_word_2,
  input  logic signed [COORD_BITS-1:0] vol_word_3,
  input  logic signed [COORD_BITS-1:0] vol_word_4,
  input  logic signed [COORD_BITS-1:0] vol_word_5,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] query_z,
  input  logic [COORD_BITS-2:0]        query_radius,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         hit,
  output int                           mismatch_count,
  output int                           outstanding,
  output int                           checked_count,
  output int                           hit_count
);

  bit pending_hits[$];
  bit predicted;

  // Squared gap from q to the interval spanned by a and b, in either order.
  function automatic longint axis_gap_sq(longint q, longint a, longint b);
    longint lo;
    longint hi;
    longint d;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    d = 0;
    if (q < lo) d = lo - q;
    else if (q > hi) d = q - hi;
    return d * d;
  endfunction

  // Coordinates stay under 26 bits, so every square and sum fits in 64 bits.
  function automatic bit compute_hit(logic op_bit, logic [1:0] vt,
                                     longint w0, longint w1, longint w2,
                                     longint w3, longint w4, longint w5,
                                     longint qx, longint qy, longint qz,
                                     longint rq);
    longint d2;
    longint reach;
    bit result;
    result = 1'b0;
    if (vt == vpsh_pkg::VT_BOX) begin
      if (op_bit == vpsh_pkg::OP_POINT)
        result = qx >= w0 && qx <= w1 && qy >= w2 && qy <= w3 && qz >= w4 && qz <= w5;
      else
        result = axis_gap_sq(qx, w0, w1) + axis_gap_sq(qy, w2, w3) +
                 axis_gap_sq(qz, w4, w5) <= rq * rq;
    end else if (vt == vpsh_pkg::VT_SPHERE) begin
      d2 = (qx - w0) * (qx - w0) + (qy - w1) * (qy - w1) + (qz - w2) * (qz - w2);
      // a negative sphere radius is taken as given
      if (op_bit == vpsh_pkg::OP_POINT) begin
        reach = w3;
        result = d2 <= reach * reach;
      end else begin
        reach = rq + w3;
        result = d2 < reach * reach;
      end
    end
    return result;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_hits.push_back(compute_hit(op, vol_type, vol_word_0, vol_word_1,
                                           vol_word_2, vol_word_3, vol_word_4,
                                           vol_word_5, query_x, query_y, query_z,
                                           longint'(query_radius)));
      if (out_valid && !out_stall) begin
        checked_count++;
        if (hit === 1'b1) hit_count++;
        if (pending_hits.size() == 0) begin
          report_mismatch($sformatf("result hit=%0b with no request outstanding", hit));
        end else begin
          predicted = pending_hits.pop_front();
          if (hit !== predicted)
            report_mismatch($sformatf("hit=%0b, predicted %0b (result %0d)",
                                      hit, predicted, checked_count));
        end
      end
    end
    outstanding <= pending_hits.size();
  end

endmodule

@@ tb/sv/volume_point_sphere_hit_test_tb.sv @@
// Testbench top for volume_point_sphere_hit_test: clock, reset, request stimulus
// with bursts and gaps, receiver stalls, watchdog and verdict.
// Depends on vpsh_pkg, the block itself and hit_test_scoreboard.
`timescale 1ns / 1ps

module volume_point_sphere_hit_test_tb;

  localparam int COORD_BITS = 24;
  localparam logic [1:0] VT_UNKNOWN = 2'd2;
  localparam logic [1:0] VT_RESERVED = 2'd3;
  localparam int U = 256;  // 1.0 in Q15.8
  localparam int C_MAX = 8388607;
  localparam int C_MIN = -8388608;
  localparam int R_MAX = 8388607;
  localparam int RANDOM_COUNT = 1780;
  localparam int HOLD_START = 1500;
  localparam int HOLD_LEN = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  localparam int STALL_NONE = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_PERIODIC = 3;

  typedef struct packed {
    logic                         op;
    logic [1:0]                   vt;
    logic signed [COORD_BITS-1:0] w0;
    logic signed [COORD_BITS-1:0] w1;
    logic signed [COORD_BITS-1:0] w2;
    logic signed [COORD_BITS-1:0] w3;
    logic signed [COORD_BITS-1:0] w4;
    logic signed [COORD_BITS-1:0] w5;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    logic signed [COORD_BITS-1:0] qz;
    logic [COORD_BITS-2:0]        rq;
  } hit_request_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         op = 1'b0;
  logic [1:0]                   vol_type = '0;
  logic signed [COORD_BITS-1:0] vol_word_0 = '0;
  logic signed [COORD_BITS-1:0] vol_word_1 = '0;
  logic signed [COORD_BITS-1:0] vol_word_2 = '0;
  logic signed [COORD_BITS-1:0] vol_word_3 = '0;
  logic signed [COORD_BITS-1:0] vol_word_4 = '0;
  logic signed [COORD_BITS-1:0] vol_word_5 = '0;
  logic signed [COORD_BITS-1:0] query_x = '0;
  logic signed [COORD_BITS-1:0] query_y = '0;
  logic signed [COORD_BITS-1:0] query_z = '0;
  logic [COORD_BITS-2:0]        query_radius = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic                         hit;

  int mismatch_count;
  int outstanding;
  int checked_count;
  int hit_count;
  int sent_count;
  int idle_cycles;
  int burst_left;

  volume_point_sphere_hit_test #(.COORD_BITS(COORD_BITS)) u_top (.*);

  hit_test_scoreboard #(.COORD_BITS(COORD_BITS)) u_scoreboard (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic hit_request_t make_req(logic op_bit, logic [1:0] vt,
                                            int w0, int w1, int w2, int w3, int w4, int w5,
                                            int qx, int qy, int qz, int rq);
    hit_request_t req;
    req.op = op_bit;
    req.vt = vt;
    req.w0 = w0[COORD_BITS-1:0];
    req.w1 = w1[COORD_BITS-1:0];
    req.w2 = w2[COORD_BITS-1:0];
    req.w3 = w3[COORD_BITS-1:0];
    req.w4 = w4[COORD_BITS-1:0];
    req.w5 = w5[COORD_BITS-1:0];
    req.qx = qx[COORD_BITS-1:0];
    req.qy = qy[COORD_BITS-1:0];
    req.qz = qz[COORD_BITS-1:0];
    req.rq = rq[COORD_BITS-2:0];
    return req;
  endfunction

  // Uniform signed value of the given width.
  function automatic int rand_coord(int bits);
    int span;
    span = 1 << bits;
    return int'($urandom_range(0, span - 1)) - span / 2;
  endfunction

  function automatic hit_request_t random_request();
    int bits;
    int pick;
    int lo;
    int hi;
    int t;
    int w[6];
    int q[3];
    int rq;
    logic op_bit;
    logic [1:0] vt;
    // mostly small coordinates so hits are common; full width now and then
    bits = ($urandom_range(0, 7) == 0) ? COORD_BITS : $urandom_range(4, 14);
    op_bit = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 45) vt = vpsh_pkg::VT_BOX;
    else if (pick < 90) vt = vpsh_pkg::VT_SPHERE;
    else vt = $urandom_range(0, 1) ? VT_UNKNOWN : VT_RESERVED;
    foreach (w[i]) w[i] = rand_coord(bits);
    foreach (q[i]) q[i] = rand_coord(bits);
    if (bits == COORD_BITS) rq = $urandom_range(0, R_MAX);
    else rq = $urandom_range(0, (1 << (bits - 1)) - 1);
    if (vt == vpsh_pkg::VT_BOX && $urandom_range(0, 4) != 0) begin
      for (int k = 0; k < 3; k++) begin
        lo = (w[2*k] < w[2*k+1]) ? w[2*k] : w[2*k+1];
        hi = (w[2*k] < w[2*k+1]) ? w[2*k+1] : w[2*k];
        w[2*k] = lo;
        w[2*k+1] = hi;
        t = $urandom_range(0, 5);
        // place the point inside or on a face of the ordered box
        if (t < 2) q[k] = lo + int'($urandom_range(0, hi - lo));
        else if (t == 2) q[k] = $urandom_range(0, 1) ? lo : hi;
      end
    end else if (vt == vpsh_pkg::VT_SPHERE && bits < COORD_BITS) begin
      if ($urandom_range(0, 9) != 0) w[3] = $urandom_range(0, (1 << (bits - 1)) - 1);
      t = $urandom_range(0, 5);
      if (t == 0) begin
        // on the surface, or exactly touching for the sphere test
        q[0] = w[0] + ((op_bit == vpsh_pkg::OP_POINT) ? w[3] : rq + w[3]);
        q[1] = w[1];
        q[2] = w[2];
      end else if (t < 4) begin
        for (int k = 0; k < 3; k++) q[k] = w[k] + rand_coord(bits - 1);
      end
    end
    return make_req(op_bit, vt, w[0], w[1], w[2], w[3], w[4], w[5],
                    q[0], q[1], q[2], rq);
  endfunction

  // Offer one request, hold it until taken, then pace the next one.
  task automatic send_request(input hit_request_t req);
    int gap;
    in_valid     <= 1'b1;
    op           <= req.op;
    vol_type     <= req.vt;
    vol_word_0   <= req.w0;
    vol_word_1   <= req.w1;
    vol_word_2   <= req.w2;
    vol_word_3   <= req.w3;
    vol_word_4   <= req.w4;
    vol_word_5   <= req.w5;
    query_x      <= req.qx;
    query_y      <= req.qy;
    query_z      <= req.qz;
    query_radius <= req.rq;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: stall patterns in segments, plus one long hold-off to fill the pipe.
  initial begin
    int mode;
    int seg_left;
    int cyc;
    mode = STALL_NONE;
    seg_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (seg_left == 0) begin
        mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
        seg_left = $urandom_range(20, 150);
      end
      seg_left--;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, outstanding);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    hit_request_t directed_reqs[$];
    int n_directed;
    burst_left = $urandom_range(1, 16);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // box inside, on the inclusive faces, just past a face, inverted bounds
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     -2*U, 3*U, -U, U, 0, 4*U, 0, 0, U, 0));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     -2*U, 3*U, -U, U, 0, 4*U, 3*U, U, 0, 0));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     -2*U, 3*U, -U, U, 0, 4*U, 3*U + 1, 0, U, 0));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     3*U, -2*U, -U, U, 0, 4*U, 0, 0, U, 0));
    // sphere against box: gap equal to r, one short, swapped bounds
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_BOX,
                                     -2*U, 3*U, -U, U, 0, 4*U, 5*U, 0, U, 2*U));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_BOX,
                                     -2*U, 3*U, -U, U, 0, 4*U, 5*U, 0, U, 2*U - 1));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_BOX,
                                     3*U, -2*U, U, -U, 4*U, 0, 5*U, 0, U, 2*U));
    // point on a sphere surface and just outside
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_SPHERE,
                                     U, -U, 2*U, 3*U, 0, 0, 4*U, -U, 2*U, 0));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_SPHERE,
                                     U, -U, 2*U, 3*U, 0, 0, 4*U + 1, -U, 2*U, 0));
    // spheres exactly touching miss, slight overlap hits
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_SPHERE,
                                     0, 0, 0, 2*U, 0, 0, 5*U, 0, 0, 3*U));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_SPHERE,
                                     0, 0, 0, 2*U, 0, 0, 5*U, 0, 0, 3*U + 1));
    // negative sphere radius
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_SPHERE,
                                     0, 0, 0, -3*U, 0, 0, 2*U, 0, 0, 0));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_SPHERE,
                                     0, 0, 0, -2*U, 0, 0, U, 0, 0, 4*U));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_SPHERE,
                                     0, 0, 0, -5*U, 0, 0, 2*U, 0, 0, 2*U));
    // unknown volume types never hit
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, VT_UNKNOWN,
                                     -2*U, 3*U, -U, U, 0, 4*U, 0, 0, U, R_MAX));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, VT_RESERVED,
                                     0, 0, 0, 2*U, 0, 0, 0, 0, 0, R_MAX));
    // full-range boxes and spheres at the coordinate extremes
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                                     C_MIN, C_MIN, C_MIN, R_MAX));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                                     C_MAX, C_MAX, C_MAX, 0));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_SPHERE,
                                     C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                     C_MAX, C_MAX, C_MAX, R_MAX));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_SPHERE,
                                     C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX,
                                     C_MAX, C_MAX, C_MAX, R_MAX));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_SPHERE, vpsh_pkg::VT_BOX,
                                     C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                     C_MAX, C_MAX, C_MAX, R_MAX));
    // unused words at extremes, zero-size box
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_SPHERE,
                                     0, 0, 0, U, C_MIN, C_MAX, U, 0, 0, R_MAX));
    directed_reqs.push_back(make_req(vpsh_pkg::OP_POINT, vpsh_pkg::VT_BOX,
                                     U, U, -U, -U, 7, 7, U, -U, 7, R_MAX));
    n_directed = directed_reqs.size();

    foreach (directed_reqs[i]) send_request(directed_reqs[i]);
    repeat (RANDOM_COUNT) send_request(random_request());
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d hit-test requests (%0d directed), %0d results, %0d hits,",
             sent_count, n_directed, checked_count, hit_count);
    $display("box and sphere volumes, unknown types, both tests, bursts, gaps, hold-off; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
